// ===== rtl/core/gaussian_blur_5x5_zero_pad_unit_defines.svh =====
// Assertion macros shared by the blur unit.
`ifndef GAUSSIAN_BLUR_5X5_ZERO_PAD_UNIT_DEFINES_SVH
`define GAUSSIAN_BLUR_5X5_ZERO_PAD_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gblur_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants of the 5x5 Gaussian blur unit.
package gblur_pkg;

  // Line store geometry
  localparam int unsigned MAX_WIDTH = 2048;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned LINES     = 4;
  localparam int unsigned LINE_W    = LINES * PIX_W;

  // Register and counter widths
  localparam int unsigned WIDTH_W   = 12;
  localparam int unsigned HEIGHT_W  = 16;
  localparam int unsigned ROW_W     = HEIGHT_W + 1;
  localparam int unsigned LAG_W     = WIDTH_W + 1;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);

  // Sum arithmetic
  localparam int unsigned GRP4_W = PIX_W + 2;
  localparam int unsigned GRP8_W = PIX_W + 3;
  localparam int unsigned SUM_W  = 19;

  localparam logic [SUM_W-1:0] W_CENTRE = SUM_W'(359);
  localparam logic [SUM_W-1:0] W_AXIS1  = SUM_W'(164);
  localparam logic [SUM_W-1:0] W_DIAG   = SUM_W'(75);
  localparam logic [SUM_W-1:0] W_AXIS2  = SUM_W'(16);
  localparam logic [SUM_W-1:0] W_KNIGHT = SUM_W'(7);

  // floor(x / 1444) == (x * ceil(2^30 / 1444)) >> 30 for every 19-bit x
  localparam int unsigned RECIP_W     = 20;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(743589);
  localparam int unsigned PROD_W = SUM_W + RECIP_W;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             flush;
  } pix_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] blurred_value;
    logic             frame_last;
  } pix_rsp_t;

endpackage

// ===== rtl/core/gblur_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port RAM with registered read.
module gblur_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/gaussian_blur_5x5_zero_pad_unit.sv =====
`timescale 1ns / 1ps
// 5x5 Gaussian blur with zero padding: top level.
//
// Pixel requests arrive on in_* in raster order (valid/ready); a request with
// flush set carries no pixel and pushes the window past the end of the frame.
// The source appends 2*width+2 flush requests after each frame. Blurred
// pixels leave on out_*, the last one of a frame carrying frame_last.
// Each result is floor(weighted 5x5 sum / 1444), outside pixels taken as zero.
// cfg_* writes image_width (index 0) or image_height (index 1) and restarts
// the frame; cfg_ready_o is always high. Write only while the unit is idle.
// Throughput: one request per clock while in_ready_o is high. A result belongs
// to the request accepted 2*width+2 requests earlier and is shown once the
// request that completes its window has passed line-store read, window,
// group sums, weighted sum and reciprocal multiply into the output register.
// Four line delays sit in one 2048 x 32 RAM, read and rewritten once per
// request at the current column; a same-column bypass covers width one.
// Reset sets only the sizes, counters and stage valids, with no clearing pass: stale
// line and window samples always fall outside the image and are masked.
// A stalled receiver holds the output register; the stages behind it keep
// filling, and in_ready_o drops only once all five are occupied.
`include "gaussian_blur_5x5_zero_pad_unit_defines.svh"

module gaussian_blur_5x5_zero_pad_unit
  import gblur_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // pixel requests
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pix_req_t             in_req_i,
  // blurred pixels
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pix_rsp_t             out_rsp_o,
  // register writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [WIDTH_W-1:0]  weff;
  logic [HEIGHT_W-1:0] heff;
  logic [LAG_W-1:0]    lag;
  logic                cfg_acc;
  logic                cfg_restart;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign cfg_restart = cfg_acc &&
                       (cfg_index_i == CFG_IMAGE_WIDTH || cfg_index_i == CFG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_acc) begin
      if (cfg_index_i == CFG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i[WIDTH_W-1:0];
      end
      if (cfg_index_i == CFG_IMAGE_HEIGHT) begin
        height_q <= cfg_data_i[HEIGHT_W-1:0];
      end
    end
  end

  // Zero width counts as one, oversized width is clipped to the line store
  always_comb begin
    if (width_q == '0) begin
      weff = WIDTH_W'(1);
    end else if (width_q > WIDTH_W'(MAX_WIDTH)) begin
      weff = WIDTH_W'(MAX_WIDTH);
    end else begin
      weff = width_q;
    end
  end

  assign heff = (height_q == '0) ? HEIGHT_W'(1) : height_q;
  assign lag  = {weff, 1'b0} + LAG_W'(2);

  // ---------------------------------------------------------------------------
  // Stage handshake: each stage moves when the one ahead is empty or moving
  // ---------------------------------------------------------------------------
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, out_vld_q;
  logic en1, en2, en3, en4, en5;
  logic in_acc, s1_adv;

  assign en5        = !out_vld_q || out_ready_i;
  assign en4        = !s4_vld_q  || en5;
  assign en3        = !s3_vld_q  || en4;
  assign en2        = !s2_vld_q  || en3;
  assign en1        = !s1_vld_q  || en2;
  assign in_ready_o = en1;
  assign in_acc     = in_valid_i && in_ready_o;
  assign s1_adv     = s1_vld_q && en2;

  // ---------------------------------------------------------------------------
  // Raster position of the next request and of the next result
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0]    in_col_q, in_col_d;
  logic [ROW_W-1:0]    in_row_q, in_row_d;
  logic [LAG_W-1:0]    lag_cnt_q, lag_cnt_d;
  logic [COL_W-1:0]    out_col_q, out_col_d;
  logic [HEIGHT_W-1:0] out_row_q, out_row_d;

  logic [WIDTH_W-1:0]  in_col_ext, out_col_ext;
  logic [ROW_W-1:0]    out_row_ext, heff_ext;
  logic                in_wrap, out_wrap;
  logic                in_res, in_last, in_beyond;
  logic [PIX_W-1:0]    in_pix;
  logic [4:0]          rmask, cmask;

  assign in_col_ext  = {1'b0, in_col_q};
  assign out_col_ext = {1'b0, out_col_q};
  assign out_row_ext = {1'b0, out_row_q};
  assign heff_ext    = {1'b0, heff};

  assign in_wrap   = (in_col_ext + WIDTH_W'(1)) >= weff;
  assign out_wrap  = (out_col_ext + WIDTH_W'(1)) >= weff;
  assign in_res    = (lag_cnt_q == lag);
  assign in_last   = in_res && (out_row_q == heff - HEIGHT_W'(1)) &&
                     (out_col_ext == weff - WIDTH_W'(1));
  // past the frame's last pixel the sample is zero
  assign in_beyond = in_row_q >= heff_ext;
  assign in_pix    = (in_req_i.flush || in_beyond) ? '0 : in_req_i.pixel_value;

  // window row/column inside the image, centred on the result position
  assign rmask[0] = out_row_q >= HEIGHT_W'(2);
  assign rmask[1] = out_row_q >= HEIGHT_W'(1);
  assign rmask[2] = 1'b1;
  assign rmask[3] = (out_row_ext + ROW_W'(1)) < heff_ext;
  assign rmask[4] = (out_row_ext + ROW_W'(2)) < heff_ext;
  assign cmask[0] = out_col_ext >= WIDTH_W'(2);
  assign cmask[1] = out_col_ext >= WIDTH_W'(1);
  assign cmask[2] = 1'b1;
  assign cmask[3] = (out_col_ext + WIDTH_W'(1)) < weff;
  assign cmask[4] = (out_col_ext + WIDTH_W'(2)) < weff;

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    lag_cnt_d = lag_cnt_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_restart || (in_acc && in_last)) begin
      in_col_d  = '0;
      in_row_d  = '0;
      lag_cnt_d = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (in_acc) begin
      if (in_wrap) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_W'(1);
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
      if (in_res) begin
        if (out_wrap) begin
          out_col_d = '0;
          out_row_d = out_row_q + HEIGHT_W'(1);
        end else begin
          out_col_d = out_col_q + COL_W'(1);
        end
      end else begin
        lag_cnt_d = lag_cnt_q + LAG_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      lag_cnt_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      lag_cnt_q <= lag_cnt_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line store read and rewrite, window shift
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]  s1_pix_q;
  logic [COL_W-1:0]  s1_col_q;
  logic              s1_res_q, s1_last_q;
  logic [4:0]        s1_rmask_q, s1_cmask_q;
  logic              fwd_q;
  logic [LINE_W-1:0] fwd_data_q;
  logic [LINE_W-1:0] ram_rdata, line_rd, line_wr;
  logic [PIX_W-1:0]  col_new [5];

  // same column read while it is being rewritten (width one): bypass
  assign line_rd = fwd_q ? fwd_data_q : ram_rdata;
  assign line_wr = {line_rd[LINE_W-PIX_W-1:0], s1_pix_q};

  gblur_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (line_wr),
    .re_i    (in_acc),
    .raddr_i (in_col_q),
    .rdata_o (ram_rdata)
  );

  // oldest line at the top of the window
  always_comb begin
    for (int a = 0; a < LINES; a++) begin
      col_new[a] = line_rd[(LINES-1-a)*PIX_W +: PIX_W];
    end
    col_new[4] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en1) begin
      s1_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q   <= in_pix;
      s1_col_q   <= in_col_q;
      s1_res_q   <= in_res;
      s1_last_q  <= in_last;
      s1_rmask_q <= rmask;
      s1_cmask_q <= cmask;
      fwd_q      <= s1_adv && (s1_col_q == in_col_q);
      fwd_data_q <= line_wr;
    end
  end

  logic [PIX_W-1:0] win_q [5][5];

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      for (int a = 0; a < 5; a++) begin
        for (int b = 0; b < 4; b++) begin
          win_q[a][b] <= win_q[a][b+1];
        end
        win_q[a][4] <= col_new[a];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: masking and group sums of equal weights
  // ---------------------------------------------------------------------------
  logic             s2_last_q;
  logic [4:0]       s2_rmask_q, s2_cmask_q;
  logic [PIX_W-1:0] mw [5][5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en2) begin
      s2_vld_q <= s1_vld_q && s1_res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_last_q  <= s1_last_q;
      s2_rmask_q <= s1_rmask_q;
      s2_cmask_q <= s1_cmask_q;
    end
  end

  always_comb begin
    for (int a = 0; a < 5; a++) begin
      for (int b = 0; b < 5; b++) begin
        mw[a][b] = (s2_rmask_q[a] && s2_cmask_q[b]) ? win_q[a][b] : '0;
      end
    end
  end

  logic [PIX_W-1:0]  g_ctr_q;
  logic [GRP4_W-1:0] g_ax1_q, g_dg_q, g_ax2_q, g_cr_q;
  logic [GRP8_W-1:0] g_kn_q;
  logic              s3_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en3) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q && en3) begin
      s3_last_q <= s2_last_q;
      g_ctr_q   <= mw[2][2];
      g_ax1_q   <= GRP4_W'(mw[1][2]) + GRP4_W'(mw[3][2]) +
                   GRP4_W'(mw[2][1]) + GRP4_W'(mw[2][3]);
      g_dg_q    <= GRP4_W'(mw[1][1]) + GRP4_W'(mw[1][3]) +
                   GRP4_W'(mw[3][1]) + GRP4_W'(mw[3][3]);
      g_ax2_q   <= GRP4_W'(mw[0][2]) + GRP4_W'(mw[4][2]) +
                   GRP4_W'(mw[2][0]) + GRP4_W'(mw[2][4]);
      g_kn_q    <= GRP8_W'(mw[0][1]) + GRP8_W'(mw[0][3]) +
                   GRP8_W'(mw[1][0]) + GRP8_W'(mw[1][4]) +
                   GRP8_W'(mw[3][0]) + GRP8_W'(mw[3][4]) +
                   GRP8_W'(mw[4][1]) + GRP8_W'(mw[4][3]);
      g_cr_q    <= GRP4_W'(mw[0][0]) + GRP4_W'(mw[0][4]) +
                   GRP4_W'(mw[4][0]) + GRP4_W'(mw[4][4]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: weighted sum (constant multiplies, shift-add)
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] sum_q;
  logic             s4_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en4) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_vld_q && en4) begin
      s4_last_q <= s3_last_q;
      sum_q     <= SUM_W'(g_ctr_q) * W_CENTRE + SUM_W'(g_ax1_q) * W_AXIS1 +
                   SUM_W'(g_dg_q)  * W_DIAG   + SUM_W'(g_ax2_q) * W_AXIS2 +
                   SUM_W'(g_kn_q)  * W_KNIGHT + SUM_W'(g_cr_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: divide by 1444 through the reciprocal, into the output register
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0] prod;
  pix_rsp_t          out_q;

  assign prod = PROD_W'(sum_q) * PROD_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en5) begin
      out_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_vld_q && en5) begin
      out_q.blurred_value <= prod[RECIP_SHIFT +: PIX_W];
      out_q.frame_last    <= s4_last_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `GB_ASSERT_NOW(a_col_in_row, clk_i, rst_ni, in_acc, in_col_ext < weff, "column past row width")
  `GB_ASSERT_NEXT(a_result_kept, clk_i, rst_ni, s1_adv && s1_res_q, s2_vld_q, "result dropped after window")
  `GB_ASSERT_NEXT(a_frame_restart, clk_i, rst_ni, in_acc && in_last, (in_col_q == '0) && (in_row_q == '0) && (lag_cnt_q == '0), "frame end did not restart raster")

endmodule

// ===== tb/gblur_result_check.sv =====
`timescale 1ns / 1ps
// Result checker for the 5x5 Gaussian blur unit: predicts each blurred pixel and compares.
module gblur_result_check
  import gblur_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  pix_req_t             in_req_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  pix_rsp_t             out_rsp_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          blur_pending_o
);

  localparam int unsigned LINE_LEN   = 2048;
  localparam int unsigned DIVISOR    = 1444;
  localparam int unsigned REPORT_CAP = 200;

  // four line delays side by side, then the 5x5 window (row, column)
  logic [7:0]  line_mem [0:4*LINE_LEN-1];
  logic [7:0]  win [0:4][0:4];
  logic [11:0] width_q;
  logic [15:0] height_q;
  int unsigned col_cnt;
  int unsigned row_cnt;
  int unsigned result_idx;
  pix_rsp_t    blurred_q [$];

  // weight by distance from the centre tap
  function automatic int unsigned tap_weight(input int a, input int b);
    int da;
    int db;
    da = (a < 2) ? 2 - a : a - 2;
    db = (b < 2) ? 2 - b : b - 2;
    case (da * 3 + db)
      0:       return 359;
      1, 3:    return 164;
      4:       return 75;
      2, 6:    return 16;
      5, 7:    return 7;
      default: return 1;
    endcase
  endfunction

  // advance the raster by one request; returns 1 when a blurred pixel falls due
  function automatic bit blur_step(input pix_req_t req, output pix_rsp_t rsp);
    int unsigned w, h, col, row, t, total, lag, p, r, c, sum;
    logic [7:0]  taps [0:4];
    int          a, b, k, rr, cc;
    w = (width_q == 0) ? 1 : ((width_q > LINE_LEN) ? LINE_LEN : int'(width_q));
    h = (height_q == 0) ? 1 : int'(height_q);
    col = (col_cnt >= w) ? 0 : col_cnt;
    row = row_cnt;
    t = row * w + col;
    total = w * h;
    rsp = '0;

    taps[4] = (req.flush || t >= total) ? 8'd0 : req.pixel_value;
    for (k = 0; k < 4; k++) taps[3-k] = line_mem[k*LINE_LEN + col];
    for (k = 3; k > 0; k--) line_mem[k*LINE_LEN + col] = line_mem[(k-1)*LINE_LEN + col];
    line_mem[col] = taps[4];
    for (a = 0; a < 5; a++) begin
      for (b = 0; b < 4; b++) win[a][b] = win[a][b+1];
      win[a][4] = taps[a];
    end

    col++;
    if (col >= w) begin
      col = 0;
      row++;
    end
    col_cnt = col;
    row_cnt = row;

    lag = 2 * w + 2;
    if (t < lag) return 1'b0;
    p = t - lag;
    r = p / w;
    c = p % w;
    sum = 0;
    for (a = 0; a < 5; a++) begin
      rr = int'(r) + a - 2;
      if (rr >= 0 && rr < int'(h)) begin
        for (b = 0; b < 5; b++) begin
          cc = int'(c) + b - 2;
          if (cc >= 0 && cc < int'(w)) sum += tap_weight(a, b) * win[a][b];
        end
      end
    end
    rsp.blurred_value = 8'(sum / DIVISOR);
    rsp.frame_last    = (p + 1 >= total);
    if (rsp.frame_last) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    return 1'b1;
  endfunction

  // printing stops after REPORT_CAP mismatches, counting does not
  task automatic report_mismatch(input string what);
    if (mismatch_count_o < REPORT_CAP) $display("[%0t] blur mismatch: %s", $time, what);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pix_rsp_t due;
    pix_rsp_t want;
    int       i;
    if (!rst_ni) begin
      for (i = 0; i < 4 * LINE_LEN; i++) line_mem[i] = '0;
      for (i = 0; i < 25; i++) win[i/5][i%5] = '0;
      width_q          = 12'd640;
      height_q         = 16'd480;
      col_cnt          = 0;
      row_cnt          = 0;
      result_idx       = 0;
      mismatch_count_o = 0;
      blurred_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_IMAGE_WIDTH: begin
            width_q = cfg_data_i[11:0];
            col_cnt = 0;
            row_cnt = 0;
          end
          CFG_IMAGE_HEIGHT: begin
            height_q = cfg_data_i;
            col_cnt  = 0;
            row_cnt  = 0;
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (blur_step(in_req_i, due)) blurred_q.push_back(due);
      end
      if (out_valid_i && out_ready_i) begin
        if (blurred_q.size() == 0) begin
          report_mismatch($sformatf("pixel %0d: value %0d last %0b with none expected",
                                    result_idx, out_rsp_i.blurred_value, out_rsp_i.frame_last));
        end else begin
          want = blurred_q.pop_front();
          if (out_rsp_i.blurred_value !== want.blurred_value)
            report_mismatch($sformatf("pixel %0d: value %0d, expected %0d", result_idx,
                                      out_rsp_i.blurred_value, want.blurred_value));
          if (out_rsp_i.frame_last !== want.frame_last)
            report_mismatch($sformatf("pixel %0d: frame_last %0b, expected %0b", result_idx,
                                      out_rsp_i.frame_last, want.frame_last));
        end
        result_idx++;
      end
    end
    blur_pending_o = blurred_q.size();
  end

endmodule

// ===== tb/tb_gaussian_blur_5x5_zero_pad_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for the 5x5 Gaussian blur unit: stimulus, pacing and verdict.
module tb_gaussian_blur_5x5_zero_pad_unit;
  import gblur_pkg::*;

  // generous limit on the whole run
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // settle time after the last predicted result, with margin
  localparam int unsigned QUIET_CYCLES = 12;
  // receiver hold-off long enough to fill every stage and stall the input
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned LINE_LEN     = 2048;
  // index with no register behind it; a write must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(2);

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  pix_req_t             in_req = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  pix_rsp_t             out_rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int unsigned mismatches;
  int unsigned blur_pending;

  // pacing: percentage of cycles each side sits idle
  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 70;
  logic        hold_req = 1'b0;
  logic        recv_hold = 1'b0;

  // effective frame geometry, as the unit sees it after clamping
  int unsigned cur_w = 640;
  int unsigned cur_h = 480;
  int unsigned items_sent = 0;

  gaussian_blur_5x5_zero_pad_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  gblur_result_check u_blur_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_req_i         (in_req),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_rsp_i        (out_rsp),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .blur_pending_o   (blur_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random back-pressure, overridden by the long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering
  // requests meanwhile; the unit must fill up and drop in_ready.
  initial begin : hold_off
    int unsigned n;
    wait (hold_req);
    @(posedge clk);
    recv_hold <= 1'b1;
    for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
    recv_hold <= 1'b0;
  end

  // Watchdog: a stuck handshake or a missing result ends up here.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // One pixel request. Valid is lowered only in idle cycles, so a request
  // that follows straight on keeps valid high without a glitch.
  task automatic send_req(input logic [7:0] pix, input logic fl);
    pix_req_t req;
    req.pixel_value = pix;
    req.flush       = fl;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // One register write; the channel then goes idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait for every predicted pixel to come out, then let the
  // pipeline settle. Checked at the falling edge so the checker has updated.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (blur_pending != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Write both geometry registers (order random) and track the clamped size.
  task automatic reconfigure(input logic [CFG_DAT_W-1:0] wd, input logic [CFG_DAT_W-1:0] hd);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CFG_IMAGE_WIDTH, wd);
      write_reg(CFG_IMAGE_HEIGHT, hd);
    end else begin
      write_reg(CFG_IMAGE_HEIGHT, hd);
      write_reg(CFG_IMAGE_WIDTH, wd);
    end
    cur_w = (wd[11:0] == 0) ? 1 : ((wd[11:0] > LINE_LEN) ? LINE_LEN : int'(wd[11:0]));
    cur_h = (hd == 0) ? 1 : int'(hd);
  endtask

  // Whole frame plus its tail. Tail requests mix flushes and stray pixels,
  // both of which must count as zero beyond the frame end.
  task automatic send_frame(input bit saturated);
    int unsigned n;
    logic [7:0]  pix;
    for (n = 0; n < cur_w * cur_h; n++) begin
      if (saturated) begin
        pix = 8'hFF;
      end else begin
        case ($urandom_range(0, 7))
          0:       pix = 8'h00;
          1:       pix = 8'hFF;
          default: pix = 8'($urandom);
        endcase
      end
      send_req(pix, !saturated && ($urandom_range(0, 15) == 0));
    end
    for (n = 0; n < 2 * cur_w + 2; n++) send_req(8'($urandom), $urandom_range(0, 2) != 0);
    items_sent += cur_w * cur_h + 2 * cur_w + 2;
  endtask

  // Random frames, mostly small; now and then a new geometry (zero sizes
  // included, junk in the unused width bits) or a stray spare-index write.
  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned start;
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        drain_results();
        if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE_IDX, 16'($urandom));
        if ($urandom_range(0, 4) == 0)
          reconfigure({4'($urandom), 12'($urandom_range(5, 8))}, 16'($urandom_range(5, 6)));
        else
          reconfigure({4'($urandom), 12'($urandom_range(0, 9))}, 16'($urandom_range(0, 6)));
      end
      send_frame(cur_w >= 5 && cur_h >= 5 && $urandom_range(0, 2) == 0);
    end
  endtask

  initial begin : stimulus
    int unsigned k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero width and height both act as one: a single-pixel frame. Its tail
    // has a flush carrying a pixel and stray pixels after the frame end.
    reconfigure('0, '0);
    send_req(8'hFF, 1'b0);
    send_req(8'hFF, 1'b1);
    send_req(8'hFF, 1'b0);
    send_req(8'h00, 1'b1);
    send_req(8'h5A, 1'b0);
    drain_results();

    // Spare index must leave the geometry alone; width written with junk
    // in its top bits. 3x2 frame with a flush inside it.
    write_reg(CFG_SPARE_IDX, 16'hFFFF);
    reconfigure(16'hF003, 16'd2);
    send_req(8'hFF, 1'b0);
    send_req(8'h00, 1'b0);
    send_req(8'hFF, 1'b0);
    send_req(8'hAA, 1'b1);
    send_req(8'hFF, 1'b0);
    send_req(8'hFF, 1'b0);
    for (k = 0; k < 8; k++) send_req(8'hFF, k[0]);
    items_sent += 19;

    // Three pacing regimes; the last one carries the long receiver stall,
    // started on an empty unit so the sender is offering throughout it.
    run_phase(28, 70);
    run_phase(70, 28);
    drain_results();
    hold_req <= 1'b1;
    run_phase(0, 0);

    // Tall single column at full rate: every request rewrites the line
    // store word of the request before it.
    drain_results();
    reconfigure(16'd1, 16'd12);
    send_frame(1'b0);

    drain_results();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
